/* sv/nau_pkg.sv */
// Package for the neural activation unit: widths, function codes, item types, helpers.
package nau_pkg;

	// Word format of arguments and results
	localparam int DATA_W = 16;
	localparam int FRAC_W = 12;
	localparam int KIND_W = 4;

	// Exponential argument in Q.31 and its integer part
	localparam int A_W = DATA_W + 33;
	localparam int N_W = A_W - 31;

	// Cell counts of the chains
	localparam int EXP_N = 14;
	localparam int LOG_N = 12;
	localparam int ZQ_N  = 30;
	localparam int RQ_N  = FRAC_W + 2;
	localparam int POW_N = (DATA_W - FRAC_W >= 5) ? 32 : (2 ** (DATA_W - FRAC_W));

	// Wide signed width of results before clamping; also the side-band width
	localparam int YW    = 2 * DATA_W + 4;
	localparam int AUX_W = YW;

	localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
	localparam logic signed [YW-1:0] ONE_FX = YW'(64'd1 << FRAC_W);
	localparam logic signed [YW-1:0] Y_HI = YW'((64'd1 << (DATA_W - 1)) - 64'd1);
	localparam logic signed [YW-1:0] Y_LO = -Y_HI - YW'(1);

	typedef enum logic [KIND_W-1:0] {
		K_TANH     = 4'd0,
		K_SIGMOID  = 4'd1,
		K_IDENTITY = 4'd2,
		K_SSIGMOID = 4'd3,
		K_SOFTSIGN = 4'd4,
		K_RAMP     = 4'd5,
		K_SOFTPLUS = 4'd6,
		K_INC      = 4'd7,
		K_QUAD     = 4'd8
	} kind_t;

	// Item context that travels along every stage
	typedef struct packed {
		logic              vld;
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] mag;
	} item_t;

	// Finished result
	typedef struct packed {
		logic              vld;
		logic [DATA_W-1:0] y;
		logic              sat;
		logic              bad;
	} res_t;

	// Exponent argument |x| in Q.31, doubled for tanh
	function automatic logic [A_W-1:0] arg_q31(item_t it);
		logic [A_W-1:0] a;
		a = A_W'(it.mag) << (31 - FRAC_W);
		if (it.kind == K_TANH) begin
			a = a << 1;
		end
		return a;
	endfunction

	function automatic logic [31:0] frac_q31(item_t it);
		logic [A_W-1:0] a;
		a = arg_q31(it);
		return {1'b0, a[30:0]};
	endfunction

	function automatic logic [N_W-1:0] int_part(item_t it);
		logic [A_W-1:0] a;
		a = arg_q31(it);
		return a[A_W-1:31];
	endfunction

	// Horner divisor k split as 2^t * m, m odd
	function automatic logic [1:0] div_pow2(logic [3:0] k);
		case (k)
			4'd2, 4'd6, 4'd10, 4'd14: return 2'd1;
			4'd4, 4'd12:              return 2'd2;
			4'd8:                     return 2'd3;
			default:                  return 2'd0;
		endcase
	endfunction

	function automatic logic [3:0] div_odd(logic [3:0] k);
		case (k)
			4'd3, 4'd6, 4'd12: return 4'd3;
			4'd5, 4'd10:       return 4'd5;
			4'd7, 4'd14:       return 4'd7;
			4'd9:              return 4'd9;
			4'd11:             return 4'd11;
			4'd13:             return 4'd13;
			default:           return 4'd1;
		endcase
	endfunction

	// floor(2^33 / m) for the odd divisors
	function automatic logic [31:0] recip(logic [3:0] m);
		case (m)
			4'd3:    return 32'd2863311530;
			4'd5:    return 32'd1717986918;
			4'd7:    return 32'd1227133513;
			4'd9:    return 32'd954437176;
			4'd11:   return 32'd780903144;
			4'd13:   return 32'd660764199;
			default: return 32'd0;
		endcase
	endfunction

	function automatic logic signed [YW-1:0] sext(logic [DATA_W-1:0] v);
		return {{(YW - DATA_W){v[DATA_W-1]}}, v};
	endfunction

endpackage

/* sv/nau_stream_if.sv */
// Stream interfaces of the neural activation unit: argument channel and result channel.
interface nau_in_if;
	import nau_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic signed [DATA_W-1:0] x_value;

	modport source (output valid, output kind, output x_value, input ready);
	modport sink (input valid, input kind, input x_value, output ready);
endinterface

interface nau_out_if;
	import nau_pkg::*;
	logic              valid;
	logic              ready;
	logic signed [DATA_W-1:0] y_value;
	logic              saturated;
	logic              bad_kind;

	modport source (output valid, output y_value, output saturated, output bad_kind,
		input ready);
	modport sink (input valid, input y_value, input saturated, input bad_kind,
		output ready);
endinterface

/* sv/nau_exp_cell.sv */
// One Horner step of e^-f, acc = 1 - f*acc/k, for the argument lane and the e^-1 lane.
module nau_exp_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic [3:0]     k,
	input  nau_pkg::item_t item_i,
	input  logic [31:0]    accf_i,
	input  logic [31:0]    acc1_i,
	output nau_pkg::item_t item_o,
	output logic [31:0]    accf_o,
	output logic [31:0]    acc1_o
);
	import nau_pkg::*;

	logic [1:0]  sh;
	logic [3:0]  m;
	logic [31:0] r;
	logic [31:0] f;
	logic [63:0] pf_c, p1_c;
	logic [31:0] qf_c, q1_c;
	logic [63:0] rf_c, r1_c;

	item_t       item_s1, item_s2, item_s3;
	logic [63:0] pf_s1, p1_s1;
	logic [31:0] qf_s2, q1_s2, af_s2, a1_s2;
	logic [31:0] accf_s3, acc1_s3;

	// exact floor(q/m) from an estimate that is at most one low
	function automatic logic [31:0] fix_quo(logic [31:0] q, logic [31:0] a, logic [3:0] dm);
		logic [35:0] rm;
		rm = 36'(q) - 36'(a) * 36'(dm);
		if (dm == 4'd1) begin
			return q;
		end
		return a + 32'(rm >= 36'(dm));
	endfunction

	assign sh = div_pow2(k);
	assign m  = div_odd(k);
	assign r  = recip(m);
	assign f  = frac_q31(item_i);

	// stage 1: products with the accumulators
	assign pf_c = f * accf_i;
	assign p1_c = ONE_Q31 * acc1_i;

	// stage 2: drop 2^(31+t), estimate the odd quotient by reciprocal
	assign qf_c = 32'(pf_s1 >> (6'd31 + 6'(sh)));
	assign q1_c = 32'(p1_s1 >> (6'd31 + 6'(sh)));
	assign rf_c = qf_c * r;
	assign r1_c = q1_c * r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
			item_s2 <= '0;
			item_s3 <= '0;
		end else if (en) begin
			item_s1 <= item_i;
			item_s2 <= item_s1;
			item_s3 <= item_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pf_s1   <= pf_c;
			p1_s1   <= p1_c;
			qf_s2   <= qf_c;
			q1_s2   <= q1_c;
			af_s2   <= 32'(rf_c >> 33);
			a1_s2   <= 32'(r1_c >> 33);
			accf_s3 <= ONE_Q31 - fix_quo(qf_s2, af_s2, m);
			acc1_s3 <= ONE_Q31 - fix_quo(q1_s2, a1_s2, m);
		end
	end

	assign item_o = item_s3;
	assign accf_o = accf_s3;
	assign acc1_o = acc1_s3;
endmodule

/* sv/nau_pow_cell.sv */
// One step of (e^-1)^n: multiplies the running power by e^-1 while the step index is below n.
module nau_pow_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic [4:0]     idx,
	input  nau_pkg::item_t item_i,
	input  logic [31:0]    ef_i,
	input  logic [31:0]    e1_i,
	input  logic [31:0]    p_i,
	output nau_pkg::item_t item_o,
	output logic [31:0]    ef_o,
	output logic [31:0]    e1_o,
	output logic [31:0]    p_o
);
	import nau_pkg::*;

	logic [63:0] prod;
	logic [31:0] p_nx;
	item_t       item_s1;
	logic [31:0] ef_s1, e1_s1, p_s1;

	assign prod = p_i * e1_i;
	assign p_nx = (N_W'(idx) < int_part(item_i)) ? 32'(prod >> 31) : p_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (en) begin
			item_s1 <= item_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ef_s1 <= ef_i;
			e1_s1 <= e1_i;
			p_s1  <= p_nx;
		end
	end

	assign item_o = item_s1;
	assign ef_o   = ef_s1;
	assign e1_o   = e1_s1;
	assign p_o    = p_s1;
endmodule

/* sv/nau_div_cell.sv */
// One restoring division step: settles one quotient bit of rem / den.
module nau_div_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic [4:0]              b,
	input  nau_pkg::item_t          item_i,
	input  logic [63:0]             rem_i,
	input  logic [33:0]             den_i,
	input  logic [31:0]             quo_i,
	input  logic [nau_pkg::AUX_W-1:0] aux_i,
	output nau_pkg::item_t          item_o,
	output logic [63:0]             rem_o,
	output logic [33:0]             den_o,
	output logic [31:0]             quo_o,
	output logic [nau_pkg::AUX_W-1:0] aux_o
);
	import nau_pkg::*;

	logic [63:0] dsh;
	logic        take;
	item_t       item_s1;
	logic [63:0] rem_s1;
	logic [33:0] den_s1;
	logic [31:0] quo_s1;
	logic [AUX_W-1:0] aux_s1;

	assign dsh  = 64'(den_i) << b;
	assign take = (rem_i >= dsh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (en) begin
			item_s1 <= item_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= take ? (rem_i - dsh) : rem_i;
			quo_s1 <= take ? (quo_i | (32'd1 << b)) : quo_i;
			den_s1 <= den_i;
			aux_s1 <= aux_i;
		end
	end

	assign item_o = item_s1;
	assign rem_o  = rem_s1;
	assign den_o  = den_s1;
	assign quo_o  = quo_s1;
	assign aux_o  = aux_s1;
endmodule

/* sv/nau_ln_cell.sv */
// One Horner step of the atanh series in z^2: acc = coef + z2*acc.
module nau_ln_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic [31:0]             coef,
	input  nau_pkg::item_t          item_i,
	input  logic [31:0]             z_i,
	input  logic [31:0]             z2_i,
	input  logic [nau_pkg::AUX_W-1:0] aux_i,
	input  logic [31:0]             acc_i,
	output nau_pkg::item_t          item_o,
	output logic [31:0]             z_o,
	output logic [31:0]             z2_o,
	output logic [nau_pkg::AUX_W-1:0] aux_o,
	output logic [31:0]             acc_o
);
	import nau_pkg::*;

	logic [63:0] prod;
	item_t       item_s1;
	logic [31:0] z_s1, z2_s1, acc_s1;
	logic [AUX_W-1:0] aux_s1;

	assign prod = z2_i * acc_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (en) begin
			item_s1 <= item_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1   <= z_i;
			z2_s1  <= z2_i;
			aux_s1 <= aux_i;
			acc_s1 <= coef + 32'(prod >> 31);
		end
	end

	assign item_o = item_s1;
	assign z_o    = z_s1;
	assign z2_o   = z2_s1;
	assign aux_o  = aux_s1;
	assign acc_o  = acc_s1;
endmodule

/* sv/neural_activation_unit.sv */
// Top level of the neural activation unit: chains of exponential, power, divider and series cells.
// Takes one (kind, x_value) transaction per clock while the argument side is ready and returns
// one result per transaction, in order. Every transaction passes the same fixed chain: 14
// exponential Horner cells of three stages, 16 power cells for (e^-1)^n, a 30-step divider for
// z = u/(2+u), 12 atanh series cells, a 14-step rounding divider and a few glue stages. A
// two-entry output buffer decouples the result handshake; the argument side is ready whenever
// that buffer has its spare entry free, so a new argument enters every cycle while it stays free.
module neural_activation_unit (
	input  logic     clk,
	input  logic     arst_n,
	nau_in_if.sink   operand,
	nau_out_if.source result
);
	import nau_pkg::*;

	logic en;

	// input stage
	item_t item_s0;
	logic [DATA_W-1:0] xu;
	assign xu = operand.x_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s0 <= '0;
		end else if (en) begin
			item_s0.vld  <= operand.valid;
			item_s0.kind <= operand.kind;
			item_s0.x    <= xu;
			item_s0.mag  <= xu[DATA_W-1] ? (~xu + 1'b1) : xu;
		end
	end

	// e^-f and e^-1 chain
	item_t       ex_item [EXP_N+1];
	logic [31:0] ex_f    [EXP_N+1];
	logic [31:0] ex_1    [EXP_N+1];
	assign ex_item[0] = item_s0;
	assign ex_f[0]    = ONE_Q31;
	assign ex_1[0]    = ONE_Q31;

	for (genvar i = 0; i < EXP_N; i++) begin : g_exp
		nau_exp_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .k(4'(EXP_N - i)),
			.item_i(ex_item[i]), .accf_i(ex_f[i]), .acc1_i(ex_1[i]),
			.item_o(ex_item[i+1]), .accf_o(ex_f[i+1]), .acc1_o(ex_1[i+1])
		);
	end

	// (e^-1)^n chain
	item_t       pw_item [POW_N+1];
	logic [31:0] pw_ef   [POW_N+1];
	logic [31:0] pw_e1   [POW_N+1];
	logic [31:0] pw_p    [POW_N+1];
	assign pw_item[0] = ex_item[EXP_N];
	assign pw_ef[0]   = ex_f[EXP_N];
	assign pw_e1[0]   = ex_1[EXP_N];
	assign pw_p[0]    = ONE_Q31;

	for (genvar i = 0; i < POW_N; i++) begin : g_pow
		nau_pow_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .idx(5'(i)),
			.item_i(pw_item[i]), .ef_i(pw_ef[i]), .e1_i(pw_e1[i]), .p_i(pw_p[i]),
			.item_o(pw_item[i+1]), .ef_o(pw_ef[i+1]), .e1_o(pw_e1[i+1]), .p_o(pw_p[i+1])
		);
	end

	// e = e^-n * e^-f, zero once the argument reaches 32
	item_t       item_s1;
	logic [31:0] e_s1;
	logic [63:0] ep_c;
	assign ep_c = pw_p[POW_N] * pw_ef[POW_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (en) begin
			item_s1 <= pw_item[POW_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1 <= (int_part(pw_item[POW_N]) >= N_W'(32)) ? 32'd0 : 32'(ep_c >> 31);
		end
	end

	// z = u / (2 + u) with u = e
	item_t            zd_item [ZQ_N+1];
	logic [63:0]      zd_rem  [ZQ_N+1];
	logic [33:0]      zd_den  [ZQ_N+1];
	logic [31:0]      zd_quo  [ZQ_N+1];
	logic [AUX_W-1:0] zd_aux  [ZQ_N+1];
	assign zd_item[0] = item_s1;
	assign zd_rem[0]  = 64'(e_s1) << 31;
	assign zd_den[0]  = (34'd1 << 32) + 34'(e_s1);
	assign zd_quo[0]  = '0;
	assign zd_aux[0]  = AUX_W'(e_s1);

	for (genvar i = 0; i < ZQ_N; i++) begin : g_zdiv
		nau_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .b(5'(ZQ_N - 1 - i)),
			.item_i(zd_item[i]), .rem_i(zd_rem[i]), .den_i(zd_den[i]),
			.quo_i(zd_quo[i]), .aux_i(zd_aux[i]),
			.item_o(zd_item[i+1]), .rem_o(zd_rem[i+1]), .den_o(zd_den[i+1]),
			.quo_o(zd_quo[i+1]), .aux_o(zd_aux[i+1])
		);
	end

	// z^2
	item_t            item_s2;
	logic [31:0]      z_s2, z2_s2;
	logic [AUX_W-1:0] e_s2;
	logic [63:0]      zz_c;
	assign zz_c = zd_quo[ZQ_N] * zd_quo[ZQ_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s2 <= '0;
		end else if (en) begin
			item_s2 <= zd_item[ZQ_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s2  <= zd_quo[ZQ_N];
			z2_s2 <= 32'(zz_c >> 31);
			e_s2  <= zd_aux[ZQ_N];
		end
	end

	// atanh series
	item_t            ln_item [LOG_N+1];
	logic [31:0]      ln_z    [LOG_N+1];
	logic [31:0]      ln_z2   [LOG_N+1];
	logic [AUX_W-1:0] ln_aux  [LOG_N+1];
	logic [31:0]      ln_acc  [LOG_N+1];
	assign ln_item[0] = item_s2;
	assign ln_z[0]    = z_s2;
	assign ln_z2[0]   = z2_s2;
	assign ln_aux[0]  = e_s2;
	assign ln_acc[0]  = '0;

	for (genvar i = 0; i < LOG_N; i++) begin : g_ln
		localparam logic [31:0] Coef = ONE_Q31 / (2 * (LOG_N - 1 - i) + 1);
		nau_ln_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .coef(Coef),
			.item_i(ln_item[i]), .z_i(ln_z[i]), .z2_i(ln_z2[i]),
			.aux_i(ln_aux[i]), .acc_i(ln_acc[i]),
			.item_o(ln_item[i+1]), .z_o(ln_z[i+1]), .z2_o(ln_z2[i+1]),
			.aux_o(ln_aux[i+1]), .acc_o(ln_acc[i+1])
		);
	end

	// z * series
	item_t            item_s3;
	logic [63:0]      lp_s3;
	logic [AUX_W-1:0] e_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s3 <= '0;
		end else if (en) begin
			item_s3 <= ln_item[LOG_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lp_s3 <= ln_z[LOG_N] * ln_acc[LOG_N];
			e_s3  <= ln_aux[LOG_N];
		end
	end

	// softplus and square rounding, dividend and divisor of the rounding divider
	logic [31:0]           e3;
	logic [32:0]           tln, tr;
	logic [2*DATA_W-1:0]   sq, tsq;
	logic signed [YW-1:0]  xs3, ysp;
	logic [63:0]           num_c;
	logic [33:0]           den_c;
	logic [AUX_W-1:0]      aux_c;

	assign e3  = 32'(e_s3);
	assign tln = 33'(lp_s3 >> 31) << 1;
	assign tr  = (tln + (33'd1 << (30 - FRAC_W))) >> (31 - FRAC_W);
	assign xs3 = sext(item_s3.x);
	assign ysp = ((xs3 > 0) ? xs3 : YW'(0)) + signed'(YW'(tr));
	assign sq  = item_s3.mag * item_s3.mag;
	assign tsq = ((sq >> (FRAC_W - 1)) + 1'b1) >> 1;

	always_comb begin
		num_c = '0;
		den_c = 34'(ONE_Q31) + 34'(e3);
		aux_c = '0;
		case (item_s3.kind)
			K_TANH, K_SSIGMOID: begin
				num_c = 64'(ONE_Q31 - e3) << (FRAC_W + 1);
			end
			K_SIGMOID: begin
				num_c = 64'(item_s3.x[DATA_W-1] ? e3 : ONE_Q31) << (FRAC_W + 1);
			end
			K_SOFTSIGN: begin
				num_c = 64'(item_s3.mag) << (FRAC_W + 1);
				den_c = 34'(item_s3.mag) + (34'd1 << FRAC_W);
			end
			K_SOFTPLUS: begin
				aux_c = AUX_W'(ysp);
			end
			K_QUAD: begin
				aux_c = AUX_W'(tsq);
			end
			default: begin
				aux_c = '0;
			end
		endcase
	end

	item_t            item_s4;
	logic [63:0]      num_s4;
	logic [33:0]      den_s4;
	logic [AUX_W-1:0] aux_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s4 <= '0;
		end else if (en) begin
			item_s4 <= item_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4 <= num_c;
			den_s4 <= den_c;
			aux_s4 <= aux_c;
		end
	end

	// rounding divider, quotient of twice the ratio
	item_t            rd_item [RQ_N+1];
	logic [63:0]      rd_rem  [RQ_N+1];
	logic [33:0]      rd_den  [RQ_N+1];
	logic [31:0]      rd_quo  [RQ_N+1];
	logic [AUX_W-1:0] rd_aux  [RQ_N+1];
	assign rd_item[0] = item_s4;
	assign rd_rem[0]  = num_s4;
	assign rd_den[0]  = den_s4;
	assign rd_quo[0]  = '0;
	assign rd_aux[0]  = aux_s4;

	for (genvar i = 0; i < RQ_N; i++) begin : g_rdiv
		nau_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .b(5'(RQ_N - 1 - i)),
			.item_i(rd_item[i]), .rem_i(rd_rem[i]), .den_i(rd_den[i]),
			.quo_i(rd_quo[i]), .aux_i(rd_aux[i]),
			.item_o(rd_item[i+1]), .rem_o(rd_rem[i+1]), .den_o(rd_den[i+1]),
			.quo_o(rd_quo[i+1]), .aux_o(rd_aux[i+1])
		);
	end

	// result selection and clamping
	item_t                it5;
	logic [31:0]          t5;
	logic signed [YW-1:0] ts5, xs5, aux5, y5;
	logic                 bad5, sat5;
	logic [DATA_W-1:0]    yq5;

	assign it5  = rd_item[RQ_N];
	assign t5   = (rd_quo[RQ_N] + 32'd1) >> 1;
	assign ts5  = signed'(YW'(t5));
	assign xs5  = sext(it5.x);
	assign aux5 = signed'(rd_aux[RQ_N]);

	always_comb begin
		bad5 = 1'b0;
		case (it5.kind)
			K_TANH, K_SSIGMOID, K_SOFTSIGN: y5 = it5.x[DATA_W-1] ? -ts5 : ts5;
			K_SIGMOID:  y5 = ts5;
			K_IDENTITY: y5 = xs5;
			K_RAMP:     y5 = it5.x[DATA_W-1] ? YW'(0) : xs5;
			K_SOFTPLUS: y5 = aux5;
			K_INC:      y5 = xs5 + ONE_FX;
			K_QUAD:     y5 = ONE_FX + xs5 + aux5;
			default: begin
				y5   = '0;
				bad5 = 1'b1;
			end
		endcase
	end

	always_comb begin
		sat5 = 1'b0;
		yq5  = y5[DATA_W-1:0];
		if (y5 > Y_HI) begin
			sat5 = 1'b1;
			yq5  = Y_HI[DATA_W-1:0];
		end else if (y5 < Y_LO) begin
			sat5 = 1'b1;
			yq5  = Y_LO[DATA_W-1:0];
		end
	end

	res_t fin_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_s5 <= '0;
		end else if (en) begin
			fin_s5.vld <= it5.vld;
			fin_s5.y   <= yq5;
			fin_s5.sat <= sat5;
			fin_s5.bad <= bad5;
		end
	end

	// output register with skid entry
	res_t out_q, skid_q;
	logic out_vld_q, skid_vld_q;
	logic push;

	assign en   = !skid_vld_q;
	assign push = en && fin_s5.vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (result.ready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (out_vld_q && !result.ready) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (result.ready) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_vld_q && !result.ready) begin
				skid_q <= fin_s5;
			end else begin
				out_q <= fin_s5;
			end
		end
	end

	assign operand.ready    = en;
	assign result.valid     = out_vld_q;
	assign result.y_value   = out_q.y;
	assign result.saturated = out_q.sat;
	assign result.bad_kind  = out_q.bad;

	// checks
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry held while output register empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> ($past(out_vld_q) && !$past(result.ready)))
		else $error("skid entry filled without a stalled output");

	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.bad_kind) |-> (result.y_value == '0 && !result.saturated))
		else $error("unknown function code gave a nonzero result");

	a_sat_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.saturated) |->
		(result.y_value == Y_HI[DATA_W-1:0] || result.y_value == Y_LO[DATA_W-1:0]))
		else $error("saturated result not at a range end");
endmodule
